FILE: rtl/assert_macros.svh
// Assertion macros used by the checker in lcm_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lcm_pkg.sv
package lcm_pkg;

    localparam int unsigned FIELD_WIDTH       = 32;
    localparam int unsigned OPERAND_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TZ,
        ST_ODDX,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } lcm_state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

FILE: rtl/lcm_alu.sv
module lcm_alu #(
    parameter int unsigned WIDTH = lcm_pkg::OPERAND_WIDTH_DEF + 1
) (
    input  lcm_pkg::alu_op_t   op,
    input  logic [WIDTH-1:0]   op_a,
    input  logic [WIDTH-1:0]   op_b,
    output logic [WIDTH:0]     result
);
    import lcm_pkg::*;

    // Top bit is the carry on add and the sign (a < b) on subtract.
    always_comb begin
        unique case (op)
            ALU_ADD: result = {1'b0, op_a} + {1'b0, op_b};
            ALU_SUB: result = {1'b0, op_a} - {1'b0, op_b};
        endcase
    end

endmodule

FILE: rtl/lcm_unit_core.sv
// Channel | Ports                                   | Handshake
// input   | s_first_operand, s_second_operand       | s_valid / s_ready
// result  | m_multiple, m_overflowed                | m_valid / m_ready
//
// A nonzero pair first runs through GCD steps (W = OPERAND_WIDTH): shared and extra
// factors of two, shifts, swaps and subtracts. W restoring-divide and W shift-and-add
// steps follow, all through one shared adder/subtractor. A zero operand goes from
// idle straight to the done state, which then raises m_valid.
// aresetn is synchronous, active low; it clears the sequencer and m_valid.
// s_ready is high only while idle; a result waiting in the output register stalls.
module lcm_unit_core #(
    parameter int unsigned OPERAND_WIDTH = lcm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [lcm_pkg::FIELD_WIDTH-1:0] s_first_operand,
    input  logic [lcm_pkg::FIELD_WIDTH-1:0] s_second_operand,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lcm_pkg::FIELD_WIDTH-1:0] m_multiple,
    output logic                            m_overflowed
);
    import lcm_pkg::*;

    localparam int unsigned W     = OPERAND_WIDTH;
    localparam int unsigned IN_W  = (W < FIELD_WIDTH) ? W : FIELD_WIDTH;
    localparam int unsigned CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    lcm_state_t       state_reg, state_next;
    logic [W-1:0]     x_reg, x_next;      // odd part of gcd
    logic [W-1:0]     y_reg, y_next;
    logic [W-1:0]     n_reg, n_next;      // dividend, then quotient, then low product
    logic [W-1:0]     b_reg, b_next;
    logic [W-1:0]     r_reg, r_next;      // remainder, then high product
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             zero_reg, zero_next;
    logic                   m_valid_reg, m_valid_next;
    logic [FIELD_WIDTH-1:0] m_multiple_reg, m_multiple_next;
    logic                   m_overflowed_reg, m_overflowed_next;

    logic [W-1:0]   a_in, b_in;
    alu_op_t        alu_op;
    logic [W:0]     alu_a, alu_b;
    logic [W+1:0]   alu_res;
    logic           alu_neg;
    logic           out_free;

    lcm_alu #(
        .WIDTH (W + 1)
    ) u_alu (
        .op     (alu_op),
        .op_a   (alu_a),
        .op_b   (alu_b),
        .result (alu_res)
    );

    assign a_in     = W'(s_first_operand[IN_W-1:0]);
    assign b_in     = W'(s_second_operand[IN_W-1:0]);
    assign alu_neg  = alu_res[W+1];
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_multiple   = m_multiple_reg;
    assign m_overflowed = m_overflowed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg            <= x_next;
        y_reg            <= y_next;
        n_reg            <= n_next;
        b_reg            <= b_next;
        r_reg            <= r_next;
        cnt_reg          <= cnt_next;
        zero_reg         <= zero_next;
        m_multiple_reg   <= m_multiple_next;
        m_overflowed_reg <= m_overflowed_next;
    end

    // Shared unit operands per phase.
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg) inside
            ST_GCD: begin
                alu_op = ALU_SUB;
                alu_a  = {1'b0, y_reg};
                alu_b  = {1'b0, x_reg};
            end
            ST_DIV: begin
                alu_op = ALU_SUB;
                alu_a  = {r_reg, n_reg[W-1]};
                alu_b  = {1'b0, x_reg};
            end
            ST_MUL: begin
                alu_op = ALU_ADD;
                alu_a  = {1'b0, r_reg};
                alu_b  = n_reg[0] ? {1'b0, b_reg} : '0;
            end
            ST_IDLE, ST_TZ, ST_ODDX, ST_DONE: begin
            end
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        n_next            = n_reg;
        b_next            = b_reg;
        r_next            = r_reg;
        cnt_next          = cnt_reg;
        zero_next         = zero_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_multiple_next   = m_multiple_reg;
        m_overflowed_next = m_overflowed_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = a_in;
                    y_next     = b_in;
                    n_next     = a_in;
                    b_next     = b_in;
                    zero_next  = (a_in == '0) || (b_in == '0);
                    state_next = ((a_in == '0) || (b_in == '0)) ? ST_DONE : ST_TZ;
                end
            end
            ST_TZ: begin
                // Drop common factors of two; the dividend loses them too.
                if (!x_reg[0] && !y_reg[0]) begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    n_next = n_reg >> 1;
                end else begin
                    state_next = ST_ODDX;
                end
            end
            ST_ODDX: begin
                if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (y_reg == '0) begin
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (alu_neg) begin
                    // y < x: swap so the next subtract is non-negative
                    x_next = y_reg;
                    y_next = x_reg;
                end else begin
                    y_next = alu_res[W-1:0];
                end
            end
            ST_DIV: begin
                if (alu_neg) begin
                    r_next = {r_reg[W-2:0], n_reg[W-1]};
                    n_next = {n_reg[W-2:0], 1'b0};
                end else begin
                    r_next = alu_res[W-1:0];
                    n_next = {n_reg[W-2:0], 1'b1};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                r_next   = alu_res[W:1];
                n_next   = {alu_res[0], n_reg[W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (zero_reg) begin
                        m_multiple_next   = '0;
                        m_overflowed_next = 1'b0;
                    end else if (r_reg != '0) begin
                        m_multiple_next   = '0;
                        m_overflowed_next = 1'b1;
                    end else begin
                        m_multiple_next   = FIELD_WIDTH'(n_reg[IN_W-1:0]);
                        m_overflowed_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

endmodule

FILE: rtl/lcm_chk.sv
`include "assert_macros.svh"

module lcm_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [lcm_pkg::FIELD_WIDTH-1:0] m_multiple,
    input logic                            m_overflowed
);
    import lcm_pkg::*;

    // One word at a time: accepting a word closes the input side.
    `LCM_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input ready after accept")

    // No result appears in the cycle right after a word is accepted.
    `LCM_ASSERT_NXT(a_no_instant_result, aclk, aresetn, s_valid && s_ready, !$rose(m_valid), "result too early")

    // An overflowed result carries a zero multiple.
    `LCM_ASSERT_IMP(a_ovf_zero, aclk, aresetn, m_valid && m_overflowed, m_multiple == '0, "overflow with nonzero multiple")

    // A stalled result holds.
    `LCM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_multiple) && $stable(m_overflowed), "stalled result changed")

endmodule

bind lcm_unit_core lcm_chk u_lcm_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_multiple   (m_multiple),
    .m_overflowed (m_overflowed)
);
